>>> hdl/tked_pkg.sv
package tked_pkg;

    typedef logic [1:0] t_op;
    typedef logic [7:0] t_byte;
    typedef logic [1:0] t_kind;
    typedef logic [7:0] t_code;

    // input operations
    localparam t_op OP_BYTE    = 2'd0;
    localparam t_op OP_TIMEOUT = 2'd1;
    localparam t_op OP_EOF     = 2'd2;

    // result kinds
    localparam t_kind KIND_CHAR  = 2'd0;
    localparam t_kind KIND_KEY   = 2'd1;
    localparam t_kind KIND_UNREC = 2'd2;

    // special key indices
    localparam t_code SK_UP          = 8'd0;
    localparam t_code SK_DOWN        = 8'd1;
    localparam t_code SK_LEFT        = 8'd2;
    localparam t_code SK_RIGHT       = 8'd3;
    localparam t_code SK_HOME        = 8'd4;
    localparam t_code SK_END         = 8'd5;
    localparam t_code SK_DEL         = 8'd6;
    localparam t_code SK_PGUP        = 8'd7;
    localparam t_code SK_PGDN        = 8'd8;
    localparam t_code SK_WORD_LEFT   = 8'd9;
    localparam t_code SK_WORD_RIGHT  = 8'd10;
    localparam t_code SK_WORD_DELETE = 8'd11;
    localparam t_code SK_BACKTAB     = 8'd12;
    localparam t_code SK_F1          = 8'd13;
    localparam t_code SK_F6          = 8'd18;
    localparam t_code SK_F11         = 8'd23;
    localparam t_code SK_F12         = 8'd24;
    localparam t_code SK_RUBOUT      = 8'd25;
    localparam t_code SK_RETURN      = 8'd26;
    localparam t_code SK_ESCAPE      = 8'd27;
    localparam t_code SK_EOF         = 8'd28;
    localparam t_code SK_NONE        = 8'd255;

    // bytes of interest
    localparam t_byte CH_LF    = 8'd10;
    localparam t_byte CH_BS    = 8'd8;
    localparam t_byte CH_ESC   = 8'd27;
    localparam t_byte CH_DEL   = 8'd127;
    localparam t_byte CH_LBRK  = 8'h5B;
    localparam t_byte CH_O     = 8'h4F;
    localparam t_byte CH_TILDE = 8'h7E;
    localparam t_byte CH_SEMI  = 8'h3B;
    localparam t_byte CH_ZERO  = 8'h30;
    localparam t_byte CH_NINE  = 8'h39;
    localparam t_byte CH_LC_B  = 8'h62;
    localparam t_byte CH_LC_D  = 8'h64;
    localparam t_byte CH_LC_F  = 8'h66;
    localparam t_byte CH_A     = 8'h41;
    localparam t_byte CH_B     = 8'h42;
    localparam t_byte CH_C     = 8'h43;
    localparam t_byte CH_D     = 8'h44;
    localparam t_byte CH_F     = 8'h46;
    localparam t_byte CH_H     = 8'h48;
    localparam t_byte CH_P     = 8'h50;
    localparam t_byte CH_S     = 8'h53;
    localparam t_byte CH_Z     = 8'h5A;

    localparam t_byte MOD_CTRL = 8'd5;
    localparam t_byte MOD_ALT  = 8'd3;

endpackage

>>> hdl/tked_if.sv
interface tked_in_if;
    logic          valid;
    logic          ready;
    tked_pkg::t_op   op;
    tked_pkg::t_byte in_byte;

    modport source (output valid, output op, output in_byte, input ready);
    modport sink   (input valid, input op, input in_byte, output ready);
endinterface

interface tked_out_if;
    logic          valid;
    logic          ready;
    tked_pkg::t_kind kind;
    tked_pkg::t_code code;

    modport source (output valid, output kind, output code, input ready);
    modport sink   (input valid, input kind, input code, output ready);
endinterface

>>> hdl/terminal_key_escape_decoder.sv
// Keyboard escape sequence decoder.
// i_in carries one event per transaction: a received byte, an expired wait
// window, or end of input. o_out carries zero or one key result per event:
// kind (plain character, special key, unrecognized sequence) and code.
// Latency: a result appears on o_out the cycle after its event is accepted.
// Throughput: one event per cycle while i_in.ready is high; the parser state is
// updated at the accepting edge, and so is the result register when the event gives a result.
// A single result register sits on the output. i_in.ready is high while that
// register is empty or being drained, so a stalled receiver blocks new events
// only once a result is waiting in it; events that give no result still need
// that slot free, so the stream order is always kept.
// Reset (i_rst_n low at a clock edge) returns the parser to idle and drops any
// result that was waiting on o_out.
module terminal_key_escape_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tked_in_if.sink    i_in,
    tked_out_if.source o_out
);
    import tked_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_ESC  = 3'b010,
        PH_SEQ  = 3'b100
    } t_phase;

    t_phase r_phase, n_phase;
    t_byte  r_number, n_number;
    t_byte  r_modifier, n_modifier;
    logic   r_filling, n_filling;
    logic   r_valid, n_valid;
    t_kind  r_kind, n_kind;
    t_code  r_code, n_code;

    logic   accept;
    logic   emit;
    logic   emit_raw;
    t_code  emit_key;
    logic   is_digit;

    function automatic t_byte sat_digit(t_byte acc, logic [3:0] digit);
        logic [11:0] v;
        v = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {8'd0, digit};
        return (v > 12'd255) ? 8'hFF : v[7:0];
    endfunction

    function automatic t_code tilde_key(t_byte num, t_byte modv);
        t_code k;
        unique case (num)
            8'd1, 8'd7:  k = SK_HOME;
            8'd4, 8'd8:  k = SK_END;
            8'd3:        k = (modv == MOD_CTRL) ? SK_WORD_DELETE : SK_DEL;
            8'd5:        k = SK_PGUP;
            8'd6:        k = SK_PGDN;
            8'd11, 8'd12, 8'd13, 8'd14, 8'd15: k = SK_F1 + (num - 8'd11);
            8'd17, 8'd18, 8'd19, 8'd20, 8'd21: k = SK_F6 + (num - 8'd17);
            8'd23:       k = SK_F11;
            8'd24:       k = SK_F12;
            default:     k = SK_NONE;
        endcase
        return k;
    endfunction

    function automatic t_code letter_key(t_byte ch, t_byte modv);
        t_code k;
        logic  ctl;
        ctl = (modv == MOD_CTRL) || (modv == MOD_ALT);
        priority if (ch == CH_A) k = SK_UP;
        else if (ch == CH_B)     k = SK_DOWN;
        else if (ch == CH_C)     k = ctl ? SK_WORD_RIGHT : SK_RIGHT;
        else if (ch == CH_D)     k = ctl ? SK_WORD_LEFT : SK_LEFT;
        else if (ch == CH_H)     k = SK_HOME;
        else if (ch == CH_F)     k = SK_END;
        else if (ch == CH_Z)     k = SK_BACKTAB;
        else if (ch >= CH_P && ch <= CH_S) k = SK_F1 + {6'd0, ch[1:0]};
        else                     k = SK_NONE;
        return k;
    endfunction

    assign i_in.ready = !r_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;
    assign is_digit   = (i_in.in_byte >= CH_ZERO) && (i_in.in_byte <= CH_NINE);

    // parser step: next state and the key (if any) this event produces
    always_comb begin
        n_phase    = r_phase;
        n_number   = r_number;
        n_modifier = r_modifier;
        n_filling  = r_filling;
        emit       = 1'b0;
        emit_raw   = 1'b0;
        emit_key   = SK_NONE;
        if (i_in.op != OP_BYTE && i_in.op != OP_TIMEOUT && i_in.op != OP_EOF) begin
            // unused op code: no result, state kept
        end else begin
            unique case (r_phase)
                PH_ESC: begin
                    n_phase = PH_IDLE;
                    emit    = 1'b1;
                    if (i_in.op != OP_BYTE) begin
                        emit_key = SK_ESCAPE;
                    end else if (i_in.in_byte == CH_LC_B) begin
                        emit_key = SK_WORD_LEFT;
                    end else if (i_in.in_byte == CH_LC_F) begin
                        emit_key = SK_WORD_RIGHT;
                    end else if (i_in.in_byte == CH_LC_D || i_in.in_byte == CH_DEL
                                 || i_in.in_byte == CH_BS) begin
                        emit_key = SK_WORD_DELETE;
                    end else if (i_in.in_byte == CH_LBRK || i_in.in_byte == CH_O) begin
                        n_phase    = PH_SEQ;
                        n_number   = '0;
                        n_modifier = '0;
                        n_filling  = 1'b0;
                        emit       = 1'b0;
                    end else begin
                        emit_key = SK_ESCAPE;
                    end
                end
                PH_SEQ: begin
                    if (i_in.op != OP_BYTE) begin
                        n_phase = PH_IDLE;
                        emit    = 1'b1;
                    end else if (is_digit) begin
                        if (r_filling) begin
                            n_modifier = sat_digit(r_modifier, i_in.in_byte[3:0]);
                        end else begin
                            n_number = sat_digit(r_number, i_in.in_byte[3:0]);
                        end
                    end else if (i_in.in_byte == CH_SEMI) begin
                        n_filling = 1'b1;
                    end else begin
                        n_phase = PH_IDLE;
                        emit    = 1'b1;
                        if (i_in.in_byte == CH_TILDE) begin
                            emit_key = tilde_key(r_number, r_modifier);
                        end else begin
                            emit_key = letter_key(i_in.in_byte, r_modifier);
                        end
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                    if (i_in.op == OP_EOF) begin
                        emit     = 1'b1;
                        emit_key = SK_EOF;
                    end else if (i_in.op == OP_BYTE) begin
                        emit = 1'b1;
                        if (i_in.in_byte == CH_DEL) begin
                            emit_key = SK_RUBOUT;
                        end else if (i_in.in_byte == CH_LF) begin
                            emit_key = SK_RETURN;
                        end else if (i_in.in_byte == CH_ESC) begin
                            n_phase = PH_ESC;
                            emit    = 1'b0;
                        end else begin
                            emit_raw = 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    always_comb begin
        n_valid = r_valid && !o_out.ready;
        n_kind  = r_kind;
        n_code  = r_code;
        if (accept && emit) begin
            n_valid = 1'b1;
            if (emit_raw) begin
                n_kind = KIND_CHAR;
                n_code = i_in.in_byte;
            end else if (emit_key == SK_NONE) begin
                n_kind = KIND_UNREC;
                n_code = '0;
            end else begin
                n_kind = KIND_KEY;
                n_code = emit_key;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_number   <= '0;
            r_modifier <= '0;
            r_filling  <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (accept) begin
                r_phase    <= n_phase;
                r_number   <= n_number;
                r_modifier <= n_modifier;
                r_filling  <= n_filling;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_code <= n_code;
    end

    assign o_out.valid = r_valid;
    assign o_out.kind  = r_kind;
    assign o_out.code  = r_code;

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("result pending after reset");

    a_unrec_code_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.kind == KIND_UNREC) |-> (o_out.code == '0))
        else $error("unrecognized result with nonzero code");

    a_key_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.kind == KIND_KEY) |-> (o_out.code <= SK_EOF))
        else $error("special key index out of range");

    a_idle_timeout_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_phase == PH_IDLE && i_in.op == OP_TIMEOUT)
        |=> (!o_out.valid || $past(r_valid && !o_out.ready)))
        else $error("timeout while idle produced a result");

endmodule

>>> dv/testbench.sv
module testbench;
    import tked_pkg::*;

    localparam t_op OP_RESERVED  = 2'd3;
    localparam int  RANDOM_ITEMS = 1100;
    localparam int  STALL_LIMIT  = 2000;

    typedef enum logic [1:0] {PH_IDLE, PH_AFTER_ESC, PH_IN_SEQ} t_dec_phase;
    typedef enum {RX_FREE, RX_COIN, RX_SLOW, RX_PERIODIC} t_rx_mode;

    typedef struct packed {
        t_kind kind;
        t_code code;
    } t_key_result;

    logic clk;
    logic rst_n;

    tked_in_if  ev_ch();
    tked_out_if key_ch();

    terminal_key_escape_decoder dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (ev_ch),
        .o_out   (key_ch)
    );

    // decoder state as predicted
    t_dec_phase  dec_phase;
    t_byte       seq_num;
    t_byte       seq_mod;
    logic        in_mod;

    t_key_result pending_keys[$];
    t_key_result want_key;
    int          mismatch_count;
    int          items_sent;
    int          burst_left;
    int          quiet_cycles;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic void push_key(t_code key);
        if (key == SK_NONE) begin
            pending_keys.push_back('{KIND_UNREC, 8'd0});
        end else begin
            pending_keys.push_back('{KIND_KEY, key});
        end
    endfunction

    function automatic t_byte sat_acc(t_byte acc, t_byte digit);
        int unsigned v;
        v = acc * 10 + digit;
        return (v > 255) ? 8'd255 : t_byte'(v);
    endfunction

    function automatic t_code tilde_lookup(t_byte num, t_byte modifier);
        if (num == 8'd1 || num == 8'd7) return SK_HOME;
        if (num == 8'd4 || num == 8'd8) return SK_END;
        if (num == 8'd3) return (modifier == MOD_CTRL) ? SK_WORD_DELETE : SK_DEL;
        if (num == 8'd5) return SK_PGUP;
        if (num == 8'd6) return SK_PGDN;
        if (num >= 8'd11 && num <= 8'd15) return SK_F1 + (num - 8'd11);
        if (num >= 8'd17 && num <= 8'd21) return SK_F6 + (num - 8'd17);
        if (num == 8'd23) return SK_F11;
        if (num == 8'd24) return SK_F12;
        return SK_NONE;
    endfunction

    function automatic t_code letter_lookup(t_byte ch, t_byte modifier);
        logic ctl;
        ctl = (modifier == MOD_CTRL) || (modifier == MOD_ALT);
        case (ch)
            CH_A: return SK_UP;
            CH_B: return SK_DOWN;
            CH_C: return ctl ? SK_WORD_RIGHT : SK_RIGHT;
            CH_D: return ctl ? SK_WORD_LEFT : SK_LEFT;
            CH_H: return SK_HOME;
            CH_F: return SK_END;
            CH_Z: return SK_BACKTAB;
            default: begin
                if (ch >= CH_P && ch <= CH_S) return SK_F1 + (ch - CH_P);
                return SK_NONE;
            end
        endcase
    endfunction

    function automatic void decode_event(t_op op, t_byte b);
        if (op == OP_RESERVED) return;
        case (dec_phase)
            PH_AFTER_ESC: begin
                dec_phase = PH_IDLE;
                if (op != OP_BYTE) push_key(SK_ESCAPE);
                else if (b == CH_LC_B) push_key(SK_WORD_LEFT);
                else if (b == CH_LC_F) push_key(SK_WORD_RIGHT);
                else if (b == CH_LC_D || b == CH_DEL || b == CH_BS) push_key(SK_WORD_DELETE);
                else if (b == CH_LBRK || b == CH_O) begin
                    dec_phase = PH_IN_SEQ;
                    seq_num   = 8'd0;
                    seq_mod   = 8'd0;
                    in_mod    = 1'b0;
                end else push_key(SK_ESCAPE);
            end
            PH_IN_SEQ: begin
                if (op != OP_BYTE) begin
                    dec_phase = PH_IDLE;
                    push_key(SK_NONE);
                end else if (b >= CH_ZERO && b <= CH_NINE) begin
                    if (in_mod) seq_mod = sat_acc(seq_mod, b - CH_ZERO);
                    else seq_num = sat_acc(seq_num, b - CH_ZERO);
                end else if (b == CH_SEMI) begin
                    in_mod = 1'b1;
                end else begin
                    dec_phase = PH_IDLE;
                    if (b == CH_TILDE) push_key(tilde_lookup(seq_num, seq_mod));
                    else push_key(letter_lookup(b, seq_mod));
                end
            end
            default: begin
                dec_phase = PH_IDLE;
                if (op == OP_EOF) push_key(SK_EOF);
                else if (op == OP_BYTE) begin
                    if (b == CH_DEL) push_key(SK_RUBOUT);
                    else if (b == CH_LF) push_key(SK_RETURN);
                    else if (b == CH_ESC) dec_phase = PH_AFTER_ESC;
                    else pending_keys.push_back('{KIND_CHAR, b});
                end
            end
        endcase
    endfunction

    // predict on accepted events before checking the result taken at the same edge
    always @(posedge clk) begin
        if (!rst_n) begin
            dec_phase    = PH_IDLE;
            seq_num      = 8'd0;
            seq_mod      = 8'd0;
            in_mod       = 1'b0;
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (ev_ch.valid && ev_ch.ready) begin
                decode_event(ev_ch.op, ev_ch.in_byte);
                quiet_cycles = 0;
            end
            if (key_ch.valid && key_ch.ready) begin
                quiet_cycles = 0;
                if (pending_keys.size() == 0) begin
                    report_mismatch($sformatf("result kind %0d code %0d with none expected",
                                              key_ch.kind, key_ch.code));
                end else begin
                    want_key = pending_keys.pop_front();
                    if (key_ch.kind != want_key.kind)
                        report_mismatch($sformatf("kind %0d expected %0d",
                                                  key_ch.kind, want_key.kind));
                    if (key_ch.code != want_key.code)
                        report_mismatch($sformatf("code %0d expected %0d",
                                                  key_ch.code, want_key.code));
                end
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("no transaction for %0d cycles", STALL_LIMIT);
                $display("terminal_key_escape_decoder verification failed");
                $finish;
            end
        end
    end

    // receiver stalls, switching between a few patterns
    initial begin
        t_rx_mode rx_mode;
        int       rx_len;
        int       rx_tick;
        key_ch.ready = 1'b0;
        rx_tick = 0;
        forever begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_len  = $urandom_range(8, 80);
            repeat (rx_len) begin
                @(negedge clk);
                rx_tick++;
                case (rx_mode)
                    RX_FREE:     key_ch.ready <= 1'b1;
                    RX_COIN:     key_ch.ready <= ($urandom_range(0, 1) == 1);
                    RX_SLOW:     key_ch.ready <= ($urandom_range(0, 3) == 0);
                    RX_PERIODIC: key_ch.ready <= (rx_tick % 5) != 0;
                endcase
            end
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_event(t_op op, t_byte b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0) begin
                ev_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        ev_ch.valid   <= 1'b1;
        ev_ch.op      <= op;
        ev_ch.in_byte <= b;
        do @(posedge clk); while (!ev_ch.ready);
        @(negedge clk);
        if (op != OP_RESERVED) items_sent++;
    endtask

    task automatic send_text(string s);
        foreach (s[i]) send_event(OP_BYTE, t_byte'(s[i]));
    endtask

    task automatic test_plain_bytes();
        send_event(OP_BYTE, 8'h00);
        send_event(OP_BYTE, 8'hFF);
        send_event(OP_BYTE, CH_DEL);
        send_event(OP_BYTE, CH_LF);
        send_event(OP_BYTE, CH_BS);
        send_event(OP_TIMEOUT, 8'hFF);
        send_event(OP_EOF, 8'h00);
        send_event(OP_RESERVED, 8'hFF);
    endtask

    task automatic test_word_keys();
        send_event(OP_BYTE, CH_ESC);
        send_event(OP_RESERVED, CH_LC_B);  // ignored, still after escape
        send_event(OP_BYTE, CH_LC_B);
        send_event(OP_BYTE, CH_ESC);
        send_event(OP_BYTE, CH_BS);
        send_event(OP_BYTE, CH_ESC);
        send_event(OP_TIMEOUT, 8'h00);
        send_event(OP_BYTE, CH_ESC);
        send_event(OP_BYTE, 8'hA5);
    endtask

    task automatic test_sequence_edges();
        // repeated separator, modifier saturates rather than wrapping to ctrl
        send_event(OP_BYTE, CH_ESC);
        send_event(OP_BYTE, CH_LBRK);
        send_text(";;261");
        send_event(OP_BYTE, CH_C);
        send_event(OP_BYTE, CH_ESC);
        send_event(OP_BYTE, CH_O);
        send_event(OP_EOF, 8'h00);
    endtask

    task automatic test_random_stream();
        int    start;
        int    pick;
        logic  cut;
        t_byte finals[11];
        int    tilde_nums[19];
        finals     = '{CH_A, CH_B, CH_C, CH_D, CH_H, CH_F, CH_Z, CH_P, 8'h51, 8'h52, CH_S};
        tilde_nums = '{1, 3, 4, 5, 6, 7, 8, 11, 12, 13, 14, 15, 17, 18, 19, 20, 21, 23, 24};
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick <= 1) begin
                send_event(OP_BYTE, t_byte'($urandom_range(0, 255)));
            end else if (pick == 2) begin
                send_event(OP_BYTE, CH_ESC);
                case ($urandom_range(0, 5))
                    0: send_event(OP_BYTE, CH_LC_B);
                    1: send_event(OP_BYTE, CH_LC_F);
                    2: send_event(OP_BYTE, CH_LC_D);
                    3: send_event(OP_BYTE, CH_DEL);
                    4: send_event(OP_BYTE, CH_BS);
                    default: send_event(t_op'($urandom_range(0, 3)),
                                        t_byte'($urandom_range(0, 255)));
                endcase
            end else if (pick <= 7) begin
                cut = ($urandom_range(0, 11) == 0);
                send_event(OP_BYTE, CH_ESC);
                send_event(OP_BYTE, $urandom_range(0, 1) ? CH_LBRK : CH_O);
                case ($urandom_range(0, 8))
                    0: ;
                    7: send_text($sformatf("%0d", $urandom_range(0, 300)));
                    8: repeat ($urandom_range(3, 6))
                        send_event(OP_BYTE, t_byte'(CH_ZERO + $urandom_range(0, 9)));
                    default: send_text($sformatf("%0d", tilde_nums[$urandom_range(0, 18)]));
                endcase
                if ($urandom_range(0, 2) != 0) begin
                    repeat ($urandom_range(1, 2)) send_event(OP_BYTE, CH_SEMI);
                    case ($urandom_range(0, 3))
                        0: send_event(OP_BYTE, CH_ZERO + MOD_CTRL);
                        1: send_event(OP_BYTE, CH_ZERO + MOD_ALT);
                        2: send_text($sformatf("%0d", $urandom_range(0, 9)));
                        default: send_text($sformatf("%0d", $urandom_range(0, 400)));
                    endcase
                end
                if (cut) begin
                    send_event($urandom_range(0, 1) ? OP_TIMEOUT : OP_EOF,
                               t_byte'($urandom_range(0, 255)));
                end else begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: send_event(OP_BYTE, CH_TILDE);
                        9: send_event(OP_BYTE, t_byte'($urandom_range(0, 255)));
                        default: send_event(OP_BYTE, finals[$urandom_range(0, 10)]);
                    endcase
                end
            end else if (pick == 8) begin
                send_event(t_op'($urandom_range(1, 3)), t_byte'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 6))
                    send_event(t_op'($urandom_range(0, 3)), t_byte'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        ev_ch.valid    = 1'b0;
        ev_ch.op       = OP_BYTE;
        ev_ch.in_byte  = 8'd0;
        mismatch_count = 0;
        items_sent     = 0;
        burst_left     = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_plain_bytes();
        test_word_keys();
        test_sequence_edges();
        test_random_stream();

        ev_ch.valid <= 1'b0;
        while (pending_keys.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("terminal_key_escape_decoder verification clean");
        end else begin
            $display("terminal_key_escape_decoder verification failed");
        end
        $finish;
    end
endmodule
